// ----- rtl/debug_packet_receiver_defines.svh -----
// Assertion macros shared by the receiver's modules.
// They expect signals named clk and rst in the scope where they are used.
`ifndef DEBUG_PACKET_RECEIVER_DEFINES_SVH
`define DEBUG_PACKET_RECEIVER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DPR_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("debug packet receiver: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("debug packet receiver: next-cycle check failed");

`endif

// ----- rtl/dpr_pkg.sv -----
package dpr_pkg;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_BODY = 2'd1,
    PH_CKHI = 2'd2,
    PH_CKLO = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    EV_PACKET = 2'd0,
    EV_ACK    = 2'd1,
    EV_NAK    = 2'd2
  } event_t;

  typedef struct packed {
    event_t      event_kind;
    logic        checksum_ok;
    logic [7:0]  command_byte;
    logic [1:0]  field_count;
    logic [31:0] field_zero;
    logic [31:0] field_one;
    logic [31:0] field_two;
    logic [15:0] first_decimal;
  } result_t;

  // Anything that is not a hex digit reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      v = 4'(c[3:0] + 4'd9);
    end
    return v;
  endfunction

endpackage

// ----- rtl/dpr_parser.sv -----
`include "debug_packet_receiver_defines.svh"

module dpr_parser #(
  parameter int FIELD_WIDTH = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  logic [7:0]       rx_byte,
  output logic             emit,
  output dpr_pkg::result_t result
);

  dpr_pkg::phase_t phase, phase_next;

  logic [7:0]             running_sum;
  logic [3:0]             checksum_high;
  logic [7:0]             held_command;
  logic                   command_seen;
  logic                   args_seen;
  logic [1:0]             field_index;
  logic [FIELD_WIDTH-1:0] field_store [3];
  logic [15:0]            decimal_accum;

  logic [3:0]  digit;
  logic        start;
  logic        is_body;
  logic        body_arg;
  logic        body_digit;

  assign digit      = dpr_pkg::hex_value(rx_byte);
  assign start      = take && phase == dpr_pkg::PH_IDLE && rx_byte == dpr_pkg::CH_DOLLAR;
  assign is_body    = take && phase == dpr_pkg::PH_BODY && rx_byte != dpr_pkg::CH_HASH;
  assign body_arg   = is_body && command_seen;
  assign body_digit = body_arg && rx_byte != dpr_pkg::CH_COMMA;

  always_comb begin
    phase_next = phase;
    if (take) begin
      unique case (phase)
        dpr_pkg::PH_IDLE: begin
          if (rx_byte == dpr_pkg::CH_DOLLAR) phase_next = dpr_pkg::PH_BODY;
        end
        dpr_pkg::PH_BODY: begin
          if (rx_byte == dpr_pkg::CH_HASH) phase_next = dpr_pkg::PH_CKHI;
        end
        dpr_pkg::PH_CKHI: phase_next = dpr_pkg::PH_CKLO;
        dpr_pkg::PH_CKLO: phase_next = dpr_pkg::PH_IDLE;
        default: phase_next = dpr_pkg::PH_IDLE;
      endcase
    end
  end

  always_comb begin
    emit   = 1'b0;
    result = '0;
    if (take) begin
      unique case (phase)
        dpr_pkg::PH_IDLE: begin
          if (rx_byte == dpr_pkg::CH_PLUS) begin
            emit              = 1'b1;
            result.event_kind = dpr_pkg::EV_ACK;
          end else if (rx_byte == dpr_pkg::CH_MINUS) begin
            emit              = 1'b1;
            result.event_kind = dpr_pkg::EV_NAK;
          end
        end
        dpr_pkg::PH_CKLO: begin
          emit                 = 1'b1;
          result.event_kind    = dpr_pkg::EV_PACKET;
          result.checksum_ok   = {checksum_high, digit} == running_sum;
          result.command_byte  = held_command;
          result.field_count   = args_seen ? 2'(field_index + 2'd1) : 2'd0;
          result.field_zero    = 32'(field_store[0]);
          result.field_one     = 32'(field_store[1]);
          result.field_two     = 32'(field_store[2]);
          result.first_decimal = decimal_accum;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= dpr_pkg::PH_IDLE;
      running_sum   <= '0;
      checksum_high <= '0;
      held_command  <= '0;
      command_seen  <= 1'b0;
      args_seen     <= 1'b0;
      field_index   <= '0;
      decimal_accum <= '0;
      for (int i = 0; i < 3; i++) field_store[i] <= '0;
    end else begin
      phase <= phase_next;
      if (start) begin
        running_sum   <= '0;
        checksum_high <= '0;
        held_command  <= '0;
        command_seen  <= 1'b0;
        args_seen     <= 1'b0;
        field_index   <= '0;
        decimal_accum <= '0;
        for (int i = 0; i < 3; i++) field_store[i] <= '0;
      end else begin
        if (is_body) running_sum <= running_sum + rx_byte;
        if (is_body && !command_seen) begin
          held_command <= rx_byte;
          command_seen <= 1'b1;
        end
        if (body_arg) args_seen <= 1'b1;
        // Commas past the third field are dropped; digits keep going into it.
        if (body_arg && rx_byte == dpr_pkg::CH_COMMA && field_index < 2'd2) begin
          field_index <= field_index + 2'd1;
        end
        for (int i = 0; i < 3; i++) begin
          if (body_digit && field_index == 2'(i)) begin
            field_store[i] <= {field_store[i][FIELD_WIDTH-5:0], digit};
          end
        end
        if (body_digit && field_index == 2'd0) begin
          decimal_accum <= (decimal_accum << 3) + (decimal_accum << 1) + 16'(digit);
        end
        if (take && phase == dpr_pkg::PH_CKHI) checksum_high <= digit;
      end
    end
  end

  `DPR_ASSERT_IMPL(a_ack_clean,
                   emit && result.event_kind != dpr_pkg::EV_PACKET,
                   result.field_count == 2'd0 && result.command_byte == 8'd0
                   && !result.checksum_ok)
  `DPR_ASSERT_NEXT(a_start_clears, start,
                   phase == dpr_pkg::PH_BODY && running_sum == 8'd0 && !command_seen)
  `DPR_ASSERT_IMPL(a_args_need_cmd, !command_seen, field_index == 2'd0 && !args_seen)
  `DPR_ASSERT_NEXT(a_close_idle, take && phase == dpr_pkg::PH_CKLO,
                   phase == dpr_pkg::PH_IDLE)

endmodule

// ----- rtl/dpr_out_reg.sv -----
module dpr_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  dpr_pkg::result_t load_data,
  input  logic             out_ready,
  output logic             out_valid,
  output dpr_pkg::result_t out_data
);

  // The caller loads only when the register is empty or being drained.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= load_data;
  end

endmodule

// ----- rtl/debug_packet_receiver.sv -----
// Debug link packet receiver: one received byte per input transaction.
// Latency: a result transaction is offered the cycle after the byte that causes it.
// Throughput: one byte per cycle; the only stall is a full output register
// whose result is not being taken in that cycle.
// Reset (rst, synchronous, active high) returns to idle outside any packet,
// clears the packet state and empties the output register.
module debug_packet_receiver #(
  parameter int FIELD_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  event_kind,
  output logic        checksum_ok,
  output logic [7:0]  command_byte,
  output logic [1:0]  field_count,
  output logic [31:0] field_zero,
  output logic [31:0] field_one,
  output logic [31:0] field_two,
  output logic [15:0] first_decimal
);

  logic             take;
  logic             emit;
  dpr_pkg::result_t result;
  dpr_pkg::result_t out_data;

  assign in_ready = !out_valid || out_ready;
  assign take     = in_valid && in_ready;

  dpr_parser #(
    .FIELD_WIDTH(FIELD_WIDTH)
  ) u_parser (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx_byte),
    .emit    (emit),
    .result  (result)
  );

  dpr_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (emit),
    .load_data (result),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  assign event_kind    = out_data.event_kind;
  assign checksum_ok   = out_data.checksum_ok;
  assign command_byte  = out_data.command_byte;
  assign field_count   = out_data.field_count;
  assign field_zero    = out_data.field_zero;
  assign field_one     = out_data.field_one;
  assign field_two     = out_data.field_two;
  assign first_decimal = out_data.first_decimal;

endmodule
